// ===== rtl/tla_pkg.sv =====
// Package for the timestamp latency averager.
// Holds shared widths, reset constants, command and divider types, engine states.
// No dependencies.
package tla_pkg;

   localparam int DEPTH_DEF    = 16;
   localparam int KEY_W        = 63;
   localparam int WALL_W       = 63;
   localparam int PERIOD_W     = 16;
   localparam int LAG_W        = 12;
   localparam int LAT_W        = 64;
   localparam int DIV_W        = 64;
   localparam int ENTRY_W      = KEY_W + WALL_W;
   localparam int REQ_DATA_W   = 128;
   localparam int RSP_DATA_W   = 80;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
   localparam logic [LAG_W-1:0]     LAG_MAX      = 12'hFFF;

   typedef enum logic {
      KIND_SEND = 1'b0,
      KIND_RECV = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [KEY_W-1:0]     key;
      logic [WALL_W-1:0]    wall;
   } cmd_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [PERIOD_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_W-1:0]     quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      E_IDLE,
      E_SEND,
      E_RD,
      E_CMP,
      E_ACC,
      E_DIV_LAG,
      E_WAIT_LAG,
      E_DIV_LAT,
      E_WAIT_LAT,
      E_RESP
   } eng_state_type;

endpackage

// ===== rtl/tla_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
module tla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tla_front.sv =====
// Front end: accepts request beats, classifies them and holds them in a two-entry queue.
// Depends on tla_pkg.
module tla_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [tla_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                         req_tuser,
   output logic                         cmd_valid,
   input  logic                         cmd_ready,
   output tla_pkg::cmd_type             cmd
);

   tla_pkg::cmd_type q_ff [2];
   logic             wp_ff, wp_in;
   logic             rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;
   tla_pkg::cmd_type new_cmd;

   assign req_tready = (cnt_ff != 2'd2);
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign cmd        = q_ff[rp_ff];
   assign push       = req_tvalid & req_tready;
   assign pop        = cmd_valid & cmd_ready;

   always_comb begin
      new_cmd.kind = req_tuser ? tla_pkg::KIND_RECV : tla_pkg::KIND_SEND;
      new_cmd.key  = req_tdata[tla_pkg::KEY_W-1:0];
      new_cmd.wall = req_tdata[tla_pkg::KEY_W +: tla_pkg::WALL_W];
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= new_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/tla_div.sv =====
// Restoring serial divider, one quotient bit per cycle, 64-bit dividend by 16-bit divisor.
// Depends on tla_pkg.
module tla_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tla_pkg::div_req_type  req,
   output tla_pkg::div_rsp_type  rsp
);

   localparam int STEP_W = $clog2(tla_pkg::DIV_W);

   logic [tla_pkg::DIV_W-1:0]    quo_ff, quo_in;
   logic [tla_pkg::PERIOD_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [tla_pkg::PERIOD_W:0]   shifted;
   logic [tla_pkg::PERIOD_W:0]   trial;
   logic                         fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[tla_pkg::DIV_W-1]};
      trial   = shifted - {1'b0, req.divisor};
      fits    = (shifted >= {1'b0, req.divisor});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[tla_pkg::DIV_W-2:0], fits};
         rem_in  = fits ? trial[tla_pkg::PERIOD_W-1:0] : shifted[tla_pkg::PERIOD_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(tla_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== rtl/tla_engine.sv =====
// Back end: keeps the pending-send ring, searches it on receive, accumulates and reports.
// Depends on tla_pkg, tla_ram and tla_div.
module tla_engine #(
   parameter int DEPTH = tla_pkg::DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   output logic                           cmd_ready,
   input  tla_pkg::cmd_type               cmd,
   input  logic [tla_pkg::PERIOD_W-1:0]   period,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tla_pkg::LAG_W-1:0]      rsp_lag,
   output logic [tla_pkg::LAT_W-1:0]      rsp_lat
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int STEP_W = IDX_W + tla_pkg::PERIOD_W;
   localparam int DW     = tla_pkg::DIV_W;

   tla_pkg::eng_state_type state_ff, state_in;

   tla_pkg::cmd_type            cmd_ff, cmd_in;
   logic [IDX_W-1:0]            head_ff, head_in;
   logic [IDX_W-1:0]            tail_ff, tail_in;
   logic [IDX_W-1:0]            rp_ff, rp_in;
   logic [CNT_W-1:0]            occ_ff, occ_in;
   logic [CNT_W-1:0]            idx_ff, idx_in;
   logic [IDX_W-1:0]            lag_ff, lag_in;
   logic [DW-1:0]               diff_ff, diff_in;
   logic [DW-1:0]               esum_ff, esum_in;
   logic [STEP_W-1:0]           ssum_ff, ssum_in;
   logic [tla_pkg::PERIOD_W-1:0] mcnt_ff, mcnt_in;
   logic [tla_pkg::LAG_W-1:0]   lag_res_ff, lag_res_in;
   logic [tla_pkg::LAT_W-1:0]   lat_res_ff, lat_res_in;
   logic                        out_valid_ff, out_valid_in;
   logic [tla_pkg::LAG_W-1:0]   out_lag_ff, out_lag_in;
   logic [tla_pkg::LAT_W-1:0]   out_lat_ff, out_lat_in;

   logic                        ram_we;
   logic [tla_pkg::ENTRY_W-1:0] ram_wdata;
   logic [tla_pkg::ENTRY_W-1:0] ram_rdata;
   logic [tla_pkg::KEY_W-1:0]   st_key;
   logic [tla_pkg::WALL_W-1:0]  st_wall;
   logic                        hit;
   logic [CNT_W-1:0]            lag_full;
   logic [CNT_W-1:0]            idx_next;
   logic [tla_pkg::PERIOD_W-1:0] mcnt_next;
   logic                        full;
   logic                        out_free;
   tla_pkg::div_req_type        div_req;
   tla_pkg::div_rsp_type        div_rsp;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
      logic [IDX_W-1:0] r;
      r = (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

   tla_ram #(
      .WIDTH (tla_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (ram_wdata),
      .rd_addr (rp_ff),
      .rd_data (ram_rdata)
   );

   tla_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign st_key    = ram_rdata[tla_pkg::KEY_W-1:0];
   assign st_wall   = ram_rdata[tla_pkg::KEY_W +: tla_pkg::WALL_W];
   assign hit       = (st_key == cmd_ff.key);
   assign lag_full  = occ_ff - idx_ff - CNT_W'(1);
   assign idx_next  = idx_ff + CNT_W'(1);
   assign mcnt_next = mcnt_ff + 1'b1;
   assign full      = (occ_ff == CNT_W'(DEPTH));
   assign out_free  = ~out_valid_ff | rsp_tready;
   assign ram_wdata = {cmd_ff.wall, cmd_ff.key};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tla_pkg::E_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == tla_pkg::KIND_SEND) begin
                  state_in = tla_pkg::E_SEND;
               end else if (occ_ff != '0) begin
                  state_in = tla_pkg::E_RD;
               end
            end
         end
         tla_pkg::E_SEND:     state_in = tla_pkg::E_IDLE;
         tla_pkg::E_RD:       state_in = tla_pkg::E_CMP;
         tla_pkg::E_CMP: begin
            if (hit) begin
               state_in = tla_pkg::E_ACC;
            end else if (idx_next == occ_ff) begin
               state_in = tla_pkg::E_IDLE;
            end else begin
               state_in = tla_pkg::E_RD;
            end
         end
         tla_pkg::E_ACC: begin
            state_in = (mcnt_next >= period) ? tla_pkg::E_DIV_LAG : tla_pkg::E_IDLE;
         end
         tla_pkg::E_DIV_LAG:  state_in = tla_pkg::E_WAIT_LAG;
         tla_pkg::E_WAIT_LAG: begin
            if (div_rsp.done) begin
               state_in = tla_pkg::E_DIV_LAT;
            end
         end
         tla_pkg::E_DIV_LAT:  state_in = tla_pkg::E_WAIT_LAT;
         tla_pkg::E_WAIT_LAT: begin
            if (div_rsp.done) begin
               state_in = tla_pkg::E_RESP;
            end
         end
         tla_pkg::E_RESP: begin
            if (out_free) begin
               state_in = tla_pkg::E_IDLE;
            end
         end
         default:             state_in = tla_pkg::E_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cmd_ready        = 1'b0;
      ram_we           = 1'b0;
      div_req.start    = 1'b0;
      div_req.divisor  = mcnt_ff;
      div_req.dividend = {{(DW - STEP_W - 8){1'b0}}, ssum_ff, 8'd0};
      cmd_in       = cmd_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      rp_in        = rp_ff;
      occ_in       = occ_ff;
      idx_in       = idx_ff;
      lag_in       = lag_ff;
      diff_in      = diff_ff;
      esum_in      = esum_ff;
      ssum_in      = ssum_ff;
      mcnt_in      = mcnt_ff;
      lag_res_in   = lag_res_ff;
      lat_res_in   = lat_res_ff;
      out_lag_in   = out_lag_ff;
      out_lat_in   = out_lat_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      case (state_ff)
         tla_pkg::E_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in = cmd;
               rp_in  = head_ff;
               idx_in = '0;
            end
         end
         tla_pkg::E_SEND: begin
            ram_we  = 1'b1;
            tail_in = wrap_inc(tail_ff);
            if (full) begin
               head_in = wrap_inc(head_ff);
            end else begin
               occ_in = occ_ff + CNT_W'(1);
            end
         end
         tla_pkg::E_CMP: begin
            if (hit) begin
               diff_in = {1'b0, cmd_ff.wall} - {1'b0, st_wall};
               lag_in  = lag_full[IDX_W-1:0];
               occ_in  = lag_full;
               head_in = wrap_inc(rp_ff);
            end else begin
               idx_in = idx_next;
               rp_in  = wrap_inc(rp_ff);
            end
         end
         tla_pkg::E_ACC: begin
            esum_in = esum_ff + diff_ff;
            ssum_in = ssum_ff + STEP_W'(lag_ff);
            mcnt_in = mcnt_next;
         end
         tla_pkg::E_DIV_LAG: begin
            div_req.start = 1'b1;
         end
         tla_pkg::E_WAIT_LAG: begin
            if (div_rsp.done) begin
               lag_res_in = (|div_rsp.quotient[DW-1:tla_pkg::LAG_W]) ?
                            tla_pkg::LAG_MAX : div_rsp.quotient[tla_pkg::LAG_W-1:0];
            end
         end
         tla_pkg::E_DIV_LAT: begin
            div_req.start    = 1'b1;
            div_req.dividend = esum_ff[DW-1] ?
                               (~esum_ff + {{(DW - tla_pkg::PERIOD_W){1'b0}}, mcnt_ff}) :
                               esum_ff;
         end
         tla_pkg::E_WAIT_LAT: begin
            if (div_rsp.done) begin
               lat_res_in = esum_ff[DW-1] ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;
            end
         end
         tla_pkg::E_RESP: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_lag_in   = lag_res_ff;
               out_lat_in   = lat_res_ff;
               esum_in      = '0;
               ssum_in      = '0;
               mcnt_in      = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      rp_ff      <= rp_in;
      idx_ff     <= idx_in;
      lag_ff     <= lag_in;
      diff_ff    <= diff_in;
      lag_res_ff <= lag_res_in;
      lat_res_ff <= lat_res_in;
      out_lag_ff <= out_lag_in;
      out_lat_ff <= out_lat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tla_pkg::E_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         esum_ff      <= '0;
         ssum_ff      <= '0;
         mcnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         esum_ff      <= esum_in;
         ssum_ff      <= ssum_in;
         mcnt_ff      <= mcnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_lag    = out_lag_ff;
   assign rsp_lat    = out_lat_ff;

endmodule

// ===== rtl/timestamp_latency_averager_top.sv =====
// Top level of the timestamp latency averager.
// Depends on tla_pkg, tla_front and tla_engine.
//
// Usage:
//   req_* carries one beat per event: tuser selects send (0) or receive (1),
//   tdata carries the message timestamp and the wall time. A send stores the
//   pair in a ring of DEPTH entries, evicting the oldest when full. A receive
//   searches the ring oldest-first; on a match it accumulates step lag and
//   elapsed time and drops the match and everything older.
//   After every 'period' matches one rsp_* beat reports both means.
//   csr_* writes period; write it only while the block is idle.
// Sequence:
//   A send writes one ring entry. A receive reads and compares the ring one
//   entry at a time through the registered read of the ring memory and
//   accumulates on a match; a reporting match then runs two 64-step serial
//   divisions in the shared divider. A two-beat queue decouples req_* from the engine.
// Reset: ring empty, sums and match count zero, period 100.
// Stall: a pending rsp beat holds while rsp_tready is low; the engine stops
//   only at its next report, and req_* keeps filling the queue meanwhile.
module timestamp_latency_averager_top #(
   parameter int DEPTH = tla_pkg::DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // msg_time [62:0], wall_time [125:63], zero [127:126]
   input  logic [tla_pkg::REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // avg_step_lag_q8 [11:0], avg_latency_us [75:12], zero [79:76]
   output logic [tla_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tla_pkg::PERIOD_W-1:0]   csr_data
);

   logic [tla_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic                         cmd_valid;
   logic                         cmd_ready;
   tla_pkg::cmd_type             cmd;
   logic [tla_pkg::LAG_W-1:0]    rsp_lag;
   logic [tla_pkg::LAT_W-1:0]    rsp_lat;

   assign csr_ready = 1'b1;
   assign period_in = (csr_valid & csr_ready) ? csr_data : period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= tla_pkg::PERIOD_RESET;
      end else begin
         period_ff <= period_in;
      end
   end

   tla_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   tla_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .period     (period_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_lag    (rsp_lag),
      .rsp_lat    (rsp_lat)
   );

   assign rsp_tdata = {
      {(tla_pkg::RSP_DATA_W - tla_pkg::LAG_W - tla_pkg::LAT_W){1'b0}},
      rsp_lat,
      rsp_lag
   };

endmodule

// ===== tb/sv/timestamp_latency_averager_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for timestamp_latency_averager_top: drives send and receive
// events, predicts every averaged report and compares each rsp beat field by field.
// Depends on tla_pkg and the RTL of the block; needs no other file.
module timestamp_latency_averager_top_tb;

   localparam int                         DEPTH          = tla_pkg::DEPTH_DEF;
   localparam int                         WATCHDOG_LIMIT = 4000;
   localparam int                         SETTLE_CYCLES  = 200;
   localparam int                         HOLD_CYCLES    = 400;
   localparam logic [tla_pkg::KEY_W-1:0]  KEY_MAX        = '1;
   localparam logic [tla_pkg::WALL_W-1:0] WALL_MAX       = '1;

   typedef struct packed {
      logic [tla_pkg::LAG_W-1:0] lag_q8;
      logic [tla_pkg::LAT_W-1:0] latency;
   } mean_report_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [tla_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                             req_tuser  = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [tla_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [tla_pkg::PERIOD_W-1:0]     csr_data   = '0;

   // shadow of the pending-message ring and the running sums
   logic [tla_pkg::KEY_W-1:0]        pend_key [DEPTH];
   logic [tla_pkg::WALL_W-1:0]       pend_wall [DEPTH];
   int                               pend_count = 0;
   logic [63:0]                      lat_acc    = '0;
   logic [63:0]                      lag_acc    = '0;
   logic [63:0]                      match_cnt  = '0;
   logic [tla_pkg::PERIOD_W-1:0]     period_cur = tla_pkg::PERIOD_RESET;

   mean_report_type                  report_queue [$];
   int                               reports_due  = 0;
   int                               errors       = 0;
   int                               burst_left   = 0;
   logic [63:0]                      wall_now     = '0;
   int                               idle_cycles  = 0;

   int                               hold_reqs    = 0;
   int                               hold_seen    = 0;
   int                               hold_left    = 0;
   int                               stretch_left = 0;
   int                               rx_random    = 0;
   int                               rx_density   = 100;
   logic [7:0]                       rx_pattern   = 8'hFF;

   timestamp_latency_averager_top #(.DEPTH(DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   function automatic logic [62:0] rand63();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[62:0];
   endfunction

   // drop the n oldest pending messages
   task automatic drop_oldest_pending(input int n);
      for (int k = 0; k + n < pend_count; k++) begin
         pend_key[k]  = pend_key[k + n];
         pend_wall[k] = pend_wall[k + n];
      end
      pend_count -= n;
   endtask

   task automatic track_event(input tla_pkg::kind_type kind,
                              input logic [tla_pkg::KEY_W-1:0] key,
                              input logic [tla_pkg::WALL_W-1:0] wall);
      int              hit;
      logic [63:0]     lag_mean;
      logic [63:0]     mag;
      logic [63:0]     quo;
      mean_report_type rep;
      hit = -1;
      if (kind == tla_pkg::KIND_SEND) begin
         if (pend_count >= DEPTH) drop_oldest_pending(1);
         pend_key[pend_count]  = key;
         pend_wall[pend_count] = wall;
         pend_count++;
      end else begin
         for (int i = 0; i < pend_count; i++) begin
            if (hit < 0 && pend_key[i] == key) hit = i;
         end
         if (hit >= 0) begin
            lag_acc   += 64'(pend_count - 1 - hit);
            lat_acc   += {1'b0, wall} - {1'b0, pend_wall[hit]};
            drop_oldest_pending(hit + 1);
            match_cnt += 1;
            if (match_cnt >= {48'd0, period_cur}) begin
               lag_mean   = (lag_acc * 64'd256) / match_cnt;
               rep.lag_q8 = (lag_mean > 64'(tla_pkg::LAG_MAX)) ?
                            tla_pkg::LAG_MAX : lag_mean[tla_pkg::LAG_W-1:0];
               if (lat_acc[63]) begin
                  mag         = ~lat_acc + 64'd1;
                  quo         = (mag + match_cnt - 64'd1) / match_cnt;
                  rep.latency = ~quo + 64'd1;
               end else begin
                  rep.latency = lat_acc / match_cnt;
               end
               report_queue.insert(report_queue.size(), rep);
               reports_due++;
               match_cnt = '0;
               lat_acc   = '0;
               lag_acc   = '0;
            end
         end
      end
   endtask

   // offer one beat in bursts with random gaps; return at the falling edge after acceptance
   task automatic send_beat(input tla_pkg::kind_type kind,
                            input logic [tla_pkg::KEY_W-1:0] key,
                            input logic [tla_pkg::WALL_W-1:0] wall);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, wall, key};
      do @(posedge clock); while (!req_tready);
      track_event(kind, key, wall);
      @(negedge clock);
   endtask

   task automatic send_pair(input logic [tla_pkg::KEY_W-1:0] key,
                            input logic [tla_pkg::WALL_W-1:0] w_tx,
                            input logic [tla_pkg::WALL_W-1:0] w_rx);
      send_beat(tla_pkg::KIND_SEND, key, w_tx);
      send_beat(tla_pkg::KIND_RECV, key, w_rx);
   endtask

   task automatic random_event();
      logic [tla_pkg::KEY_W-1:0]  key;
      logic [tla_pkg::WALL_W-1:0] wall;
      int                         roll;
      roll     = $urandom_range(0, 99);
      wall_now += 64'($urandom_range(1, 4000));
      wall     = ($urandom_range(0, 15) == 0) ? rand63() : wall_now[62:0];
      if (roll < 45 || (pend_count == 0 && roll < 90)) begin
         key = ($urandom_range(0, 4) == 0) ? tla_pkg::KEY_W'($urandom_range(0, 7)) : rand63();
         send_beat(tla_pkg::KIND_SEND, key, wall);
      end else if (roll < 90) begin
         key = pend_key[$urandom_range(0, pend_count - 1)];
         send_beat(tla_pkg::KIND_RECV, key, wall);
      end else begin
         key = ($urandom_range(0, 1) == 0) ? tla_pkg::KEY_W'($urandom_range(0, 7)) : rand63();
         send_beat(tla_pkg::KIND_RECV, key, wall);
      end
   endtask

   // hold until idle, then write the period register
   task automatic write_period(input logic [tla_pkg::PERIOD_W-1:0] value);
      req_tvalid <= 1'b0;
      while (report_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      period_cur = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_period();
      while (reports_due == 0) random_event();
   endtask

   task automatic test_field_extremes();
      write_period(tla_pkg::PERIOD_W'(1));
      send_pair('0, '0, WALL_MAX);
      send_pair(KEY_MAX, WALL_MAX, '0);
   endtask

   task automatic test_unmatched_receive();
      send_beat(tla_pkg::KIND_SEND, tla_pkg::KEY_W'(5), tla_pkg::WALL_W'(1000));
      send_beat(tla_pkg::KIND_RECV, tla_pkg::KEY_W'(6), tla_pkg::WALL_W'(1100));
      send_beat(tla_pkg::KIND_RECV, tla_pkg::KEY_W'(5), tla_pkg::WALL_W'(1200));
   endtask

   task automatic test_duplicate_keys();
      send_beat(tla_pkg::KIND_SEND, tla_pkg::KEY_W'(9), tla_pkg::WALL_W'(10));
      send_beat(tla_pkg::KIND_SEND, tla_pkg::KEY_W'(9), tla_pkg::WALL_W'(20));
      send_beat(tla_pkg::KIND_SEND, tla_pkg::KEY_W'(3), tla_pkg::WALL_W'(30));
      send_beat(tla_pkg::KIND_RECV, tla_pkg::KEY_W'(9), tla_pkg::WALL_W'(100));
      send_beat(tla_pkg::KIND_RECV, tla_pkg::KEY_W'(9), tla_pkg::WALL_W'(200));
   endtask

   task automatic test_ring_overflow();
      for (int k = 0; k <= DEPTH; k++) begin
         send_beat(tla_pkg::KIND_SEND, tla_pkg::KEY_W'(100 + k), tla_pkg::WALL_W'(50 * k));
      end
      send_beat(tla_pkg::KIND_RECV, tla_pkg::KEY_W'(100), tla_pkg::WALL_W'(5000));
      send_beat(tla_pkg::KIND_RECV, tla_pkg::KEY_W'(101), tla_pkg::WALL_W'(5000));
   endtask

   task automatic test_period_corners();
      write_period(tla_pkg::PERIOD_W'(0));
      send_pair(tla_pkg::KEY_W'(11), tla_pkg::WALL_W'(40), tla_pkg::WALL_W'(47));
      send_pair(tla_pkg::KEY_W'(12), tla_pkg::WALL_W'(47), tla_pkg::WALL_W'(48));
      write_period(16'hFFFF);
      send_beat(tla_pkg::KIND_SEND, tla_pkg::KEY_W'(20), tla_pkg::WALL_W'(900));
      send_beat(tla_pkg::KIND_SEND, tla_pkg::KEY_W'(21), tla_pkg::WALL_W'(800));
      send_beat(tla_pkg::KIND_SEND, tla_pkg::KEY_W'(22), tla_pkg::WALL_W'(700));
      send_beat(tla_pkg::KIND_RECV, tla_pkg::KEY_W'(20), tla_pkg::WALL_W'(100));
      send_pair(tla_pkg::KEY_W'(23), tla_pkg::WALL_W'(1000), tla_pkg::WALL_W'(3));
      send_pair(tla_pkg::KEY_W'(24), tla_pkg::WALL_W'(10), tla_pkg::WALL_W'(2));
      // lower the period below the count: the next match reports over the true count
      write_period(tla_pkg::PERIOD_W'(1));
      send_beat(tla_pkg::KIND_RECV, tla_pkg::KEY_W'(22), tla_pkg::WALL_W'(5));
      write_period(tla_pkg::PERIOD_W'(3));
      send_pair(tla_pkg::KEY_W'(30), tla_pkg::WALL_W'(100), tla_pkg::WALL_W'(90));
      send_pair(tla_pkg::KEY_W'(31), tla_pkg::WALL_W'(100), tla_pkg::WALL_W'(99));
      send_pair(tla_pkg::KEY_W'(32), tla_pkg::WALL_W'(100), tla_pkg::WALL_W'(100));
   endtask

   task automatic test_receiver_backpressure();
      write_period(tla_pkg::PERIOD_W'(1));
      hold_reqs <= hold_reqs + 1;
      for (int k = 0; k < 40; k++) begin
         wall_now += 64'($urandom_range(1, 500));
         send_pair(rand63(), wall_now[62:0],
                   wall_now[62:0] + tla_pkg::WALL_W'($urandom_range(0, 99)));
      end
   endtask

   task automatic test_random_traffic();
      int periods [7] = '{2, 5, 1, 7, 3, 16, 4};
      foreach (periods[p]) begin
         write_period(tla_pkg::PERIOD_W'(periods[p]));
         repeat (140) random_event();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_period();
      test_field_extremes();
      test_unmatched_receive();
      test_duplicate_keys();
      test_ring_overflow();
      test_period_corners();
      test_receiver_backpressure();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (report_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (report_queue.size() != 0) errors++;
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // receiver: stall patterns in stretches, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_reqs) begin
         hold_seen = hold_reqs;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (stretch_left == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  rx_random  = 0;
                  rx_pattern = 8'hFF;
               end
               1: begin
                  rx_random  = 0;
                  rx_pattern = 8'($urandom) | 8'h01;
               end
               2: begin
                  rx_random  = 1;
                  rx_density = 50;
               end
               default: begin
                  rx_random  = 1;
                  rx_density = 90;
               end
            endcase
            stretch_left = $urandom_range(32, 400);
         end
         stretch_left--;
         rsp_tready <= rx_random ? ($urandom_range(0, 99) < rx_density)
                                 : rx_pattern[stretch_left % 8];
      end
   end

   always @(posedge clock) begin
      mean_report_type got;
      mean_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.lag_q8  = rsp_tdata[tla_pkg::LAG_W-1:0];
         got.latency = rsp_tdata[tla_pkg::LAG_W +: tla_pkg::LAT_W];
         if (report_queue.size() == 0) begin
            $display("%0t: unexpected report beat, lag_q8 %0d latency %0d",
                     $time, got.lag_q8, $signed(got.latency));
            errors++;
         end else begin
            want = report_queue.pop_front();
            if (got.lag_q8 !== want.lag_q8) begin
               $display("%0t: avg_step_lag_q8 expected %0d actual %0d",
                        $time, want.lag_q8, got.lag_q8);
               errors++;
            end
            if (got.latency !== want.latency) begin
               $display("%0t: avg_latency_us expected %0d actual %0d",
                        $time, $signed(want.latency), $signed(got.latency));
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
